[src/dda_pkg.sv]
// Shared types and constants for the line rasterizer.
// Holds the request and response word layouts and the controller/datapath interface.
// No dependencies.
package dda_pkg;

   localparam int COORD_WIDTH = 12;
   localparam int FRAC_BITS   = 16;

   localparam int POS_WIDTH  = COORD_WIDTH + FRAC_BITS + 1;
   localparam int STEP_WIDTH = FRAC_BITS + 2;
   localparam int REM_WIDTH  = COORD_WIDTH + 1;
   // Dividend of one increment: |d| * 2^FRAC_BITS + steps / 2.
   localparam int NUM_WIDTH  = COORD_WIDTH + FRAC_BITS + 1;
   localparam int CNT_WIDTH  = $clog2(NUM_WIDTH);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef struct packed {
      logic                          op;
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic                          last;
   } rsp_type;

   typedef struct packed {
      logic load_line;
      logic do_step;
      logic div_run;
   } dp_cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic rem_zero;
      logic div_done;
   } dp_stat_type;

endpackage

[src/dda_ctrl.sv]
// Controller of the line rasterizer: handshakes and the divide sequence.
// Depends on dda_pkg.
module dda_ctrl import dda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_op,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output logic        req_ready,
   output logic        rsp_valid,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // A new word may enter only when the output register is free or being emptied.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load_line = accept && (req_op == OP_START);
   assign cmd.do_step   = accept && (req_op == OP_STEP) && !stat.rem_zero;
   assign cmd.div_run   = (state_ff == ST_DIV);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_line && !stat.steps_zero) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.do_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/dda_datapath.sv]
// Datapath of the line rasterizer: endpoint setup, two bit-serial dividers,
// position accumulators and the output register. Depends on dda_pkg.
module dda_datapath import dda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   typedef struct packed {
      logic [COORD_WIDTH-1:0] rm;
      logic [NUM_WIDTH-1:0]   nq;
   } div_lane_type;

   // One restoring-division step; the dividend shifts out the top of nq
   // while quotient bits shift in at the bottom.
   function automatic div_lane_type div_iter(input logic [COORD_WIDTH-1:0] rm,
                                             input logic [NUM_WIDTH-1:0]   nq,
                                             input logic [COORD_WIDTH-1:0] dvs);
      logic [COORD_WIDTH:0] sh;
      logic                 ge;
      div_lane_type         res;
      sh     = {rm, nq[NUM_WIDTH-1]};
      ge     = sh >= {1'b0, dvs};
      res.rm = ge ? COORD_WIDTH'(sh - {1'b0, dvs}) : sh[COORD_WIDTH-1:0];
      res.nq = {nq[NUM_WIDTH-2:0], ge};
      return res;
   endfunction

   function automatic logic [STEP_WIDTH-1:0] signed_incr(input logic [NUM_WIDTH-1:0] q,
                                                         input logic neg);
      logic [STEP_WIDTH-1:0] m;
      m = STEP_WIDTH'(q[FRAC_BITS:0]);
      return neg ? STEP_WIDTH'(-m) : m;
   endfunction

   // Round to integer, half away from zero. A negative position adds one less
   // than a half before the floor, which moves its ties away from zero too.
   function automatic logic [COORD_WIDTH-1:0] round_pos(input logic [POS_WIDTH-1:0] p);
      logic [POS_WIDTH:0]     s;
      logic [COORD_WIDTH-1:0] r;
      s = {p[POS_WIDTH-1], p} +
          (POS_WIDTH+1)'({~p[POS_WIDTH-1], {(FRAC_BITS-1){p[POS_WIDTH-1]}}});
      r = s[FRAC_BITS +: COORD_WIDTH];
      return r;
   endfunction

   logic signed [COORD_WIDTH:0]   dx, dy;
   logic [COORD_WIDTH-1:0]        ax, ay, steps;
   logic [NUM_WIDTH-1:0]          num_x, num_y;

   logic signed [POS_WIDTH-1:0]   pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic signed [STEP_WIDTH-1:0]  step_x_ff, step_y_ff, step_x_in, step_y_in;
   logic [REM_WIDTH-1:0]          remaining_ff, remaining_in;
   logic [COORD_WIDTH-1:0]        rm_x_ff, rm_y_ff, rm_x_in, rm_y_in;
   logic [NUM_WIDTH-1:0]          nq_x_ff, nq_y_ff, nq_x_in, nq_y_in;
   logic [COORD_WIDTH-1:0]        dvs_ff, dvs_in;
   logic                          neg_x_ff, neg_y_ff, neg_x_in, neg_y_in;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   rsp_type                       rsp_ff, rsp_in;

   logic signed [POS_WIDTH-1:0]   pos_x_nx, pos_y_nx;
   div_lane_type                  lane_x, lane_y;

   // Endpoint setup for a start word.
   assign dx    = (COORD_WIDTH+1)'(req_data.end_x) - (COORD_WIDTH+1)'(req_data.start_x);
   assign dy    = (COORD_WIDTH+1)'(req_data.end_y) - (COORD_WIDTH+1)'(req_data.start_y);
   assign ax    = dx[COORD_WIDTH] ? COORD_WIDTH'(-dx) : dx[COORD_WIDTH-1:0];
   assign ay    = dy[COORD_WIDTH] ? COORD_WIDTH'(-dy) : dy[COORD_WIDTH-1:0];
   assign steps = (ax > ay) ? ax : ay;
   assign num_x = (NUM_WIDTH'(ax) << FRAC_BITS) + NUM_WIDTH'(steps >> 1);
   assign num_y = (NUM_WIDTH'(ay) << FRAC_BITS) + NUM_WIDTH'(steps >> 1);

   assign lane_x = div_iter(rm_x_ff, nq_x_ff, dvs_ff);
   assign lane_y = div_iter(rm_y_ff, nq_y_ff, dvs_ff);

   assign pos_x_nx = pos_x_ff + POS_WIDTH'(step_x_ff);
   assign pos_y_nx = pos_y_ff + POS_WIDTH'(step_y_ff);

   assign stat.steps_zero = (steps == '0);
   assign stat.rem_zero   = (remaining_ff == '0);
   assign stat.div_done   = (cnt_ff == CNT_WIDTH'(NUM_WIDTH - 1));

   assign rsp_data = rsp_ff;

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      remaining_in = remaining_ff;
      rm_x_in      = rm_x_ff;
      rm_y_in      = rm_y_ff;
      nq_x_in      = nq_x_ff;
      nq_y_in      = nq_y_ff;
      dvs_in       = dvs_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      if (cmd.load_line) begin
         pos_x_in     = {req_data.start_x[COORD_WIDTH-1], req_data.start_x, FRAC_BITS'(0)};
         pos_y_in     = {req_data.start_y[COORD_WIDTH-1], req_data.start_y, FRAC_BITS'(0)};
         step_x_in    = '0;
         step_y_in    = '0;
         remaining_in = REM_WIDTH'(steps);
         rm_x_in      = '0;
         rm_y_in      = '0;
         nq_x_in      = num_x;
         nq_y_in      = num_y;
         dvs_in       = steps;
         neg_x_in     = dx[COORD_WIDTH];
         neg_y_in     = dy[COORD_WIDTH];
         cnt_in       = '0;
      end else if (cmd.div_run) begin
         rm_x_in = lane_x.rm;
         rm_y_in = lane_y.rm;
         nq_x_in = lane_x.nq;
         nq_y_in = lane_y.nq;
         cnt_in  = cnt_ff + CNT_WIDTH'(1);
         if (stat.div_done) begin
            step_x_in = signed_incr(lane_x.nq, neg_x_ff);
            step_y_in = signed_incr(lane_y.nq, neg_y_ff);
         end
      end else if (cmd.do_step) begin
         pos_x_in       = pos_x_nx;
         pos_y_in       = pos_y_nx;
         remaining_in   = remaining_ff - REM_WIDTH'(1);
         rsp_in.point_x = round_pos(pos_x_nx);
         rsp_in.point_y = round_pos(pos_y_nx);
         rsp_in.last    = (remaining_ff == REM_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         remaining_ff <= remaining_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      rm_x_ff   <= rm_x_in;
      rm_y_ff   <= rm_y_in;
      nq_x_ff   <= nq_x_in;
      nq_y_ff   <= nq_y_in;
      dvs_ff    <= dvs_in;
      neg_x_ff  <= neg_x_in;
      neg_y_ff  <= neg_y_in;
      rsp_ff    <= rsp_in;
   end

endmodule

[src/dda_line_rasterizer.sv]
// Top level of the DDA line rasterizer.
// Instantiates dda_ctrl and dda_datapath; depends on dda_pkg.
//
// Usage:
//   The req channel takes one word per handshake. A start word (op = 0)
//   carries both endpoints; it loads the start position and produces no
//   response. A step word (op = 1) advances one step and produces one rsp
//   word with the rounded point; last marks the line's end point. A step
//   word with no line active is taken and produces nothing.
//   Throughput: step words are taken one per cycle while the receiver keeps up,
//   and each response sits in the output register in the cycle after its step
//   word is taken. A start word with distinct endpoints keeps req_ready low
//   while two bit-serial dividers form the x and y increments side by side,
//   one bit of the COORD_WIDTH + FRAC_BITS + 1 bit dividend per cycle.
//   A zero-length line skips the division.
//   When the receiver stalls, the response waits in the output register and
//   req_ready drops until it is taken, so no word is lost.
//   Reset ends any active line and clears the response valid flag; the first word
//   may be sent in the cycle after reset falls.
module dda_line_rasterizer import dda_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   dda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dda_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

[src/dda_checker.sv]
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on dda_pkg.
module dda_checker import dda_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // A fresh response word follows only a taken step word.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !($past(rsp_valid) && !$past(rsp_ready)) |->
         $past(req_valid && req_ready && (req_data.op == OP_STEP)))
      else $error("response word without a step word");

   // A line of nonzero length blocks the request side while it divides.
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.op == OP_START) &&
         ((req_data.start_x != req_data.end_x) || (req_data.start_y != req_data.end_y))
         |=> !req_ready)
      else $error("request taken during increment setup");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);
